// ===== rtl/srp_pkg.sv =====
package srp_pkg;

    // Result queue depth; one item can push up to MAX_RESULTS beats at once.
    localparam int QUEUE_DEPTH = 4;
    localparam int MAX_RESULTS = 3;

    typedef enum logic [1:0] {
        KIND_PLACE  = 2'd0,
        KIND_EXTENT = 2'd1,
        KIND_REJECT = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        CFG_MAX_WIDTH    = 2'd0,
        CFG_MAX_HEIGHT   = 2'd1,
        CFG_ALLOW_ROTATE = 2'd2,
        CFG_SPACING      = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [15:0] max_w;
        logic [15:0] max_h;
        logic        rotate;
        logic [7:0]  spacing;
    } cfg_t;

    typedef struct packed {
        logic [15:0] cur_x;
        logic [15:0] cur_y;
        logic [15:0] ext_x;
        logic [15:0] ext_y;
        logic [7:0]  atlas;
        logic        in_use;
    } pack_state_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [7:0]  atlas;
        logic        rotated;
        logic        run_end;
    } result_t;

    // Saturate an 18-bit sum to 16 bits.
    function automatic logic [15:0] clip16(input logic [17:0] v);
        clip16 = (v > 18'h0FFFF) ? 16'hFFFF : v[15:0];
    endfunction

endpackage

// ===== rtl/srp_place.sv =====
module srp_place
    import srp_pkg::*;
#(
    parameter int MAX_ATLASES = 256
)
(
    input  cfg_t        cfg,
    input  pack_state_t st,
    input  logic [15:0] rect_w,
    input  logic [15:0] rect_h,
    input  logic        fin,
    output result_t     res [MAX_RESULTS],
    output logic [1:0]  res_n,
    output pack_state_t st_next
);

    logic [17:0] s2, sp18;
    logic        reject0, rot, wrap, over, has_room, new_atlas, place;
    logic [15:0] pw, ph;
    logic [15:0] cx0, cy0, ex0, ey0, cy_drop, cx, cy, ex, ey;
    logic [7:0]  ca0, ca;
    logic [17:0] bx_a, by_drop, bx, by;
    pack_state_t st_mid;
    result_t     ext_res, main_res, fin_res;
    logic        fin_emit;

    always_comb
    begin
        s2   = {9'd0, cfg.spacing, 1'b0};
        sp18 = {10'd0, cfg.spacing};

        reject0 = ({2'b00, rect_w} + s2 > {2'b00, cfg.max_w})
               || ({2'b00, rect_h} + s2 > {2'b00, cfg.max_h});

        rot = cfg.rotate && (rect_w > rect_h);
        pw  = rot ? rect_h : rect_w;
        ph  = rot ? rect_w : rect_h;

        // An idle packer opens atlas 0 at the origin.
        cx0 = st.in_use ? st.cur_x : 16'd0;
        cy0 = st.in_use ? st.cur_y : 16'd0;
        ex0 = st.in_use ? st.ext_x : 16'd0;
        ey0 = st.in_use ? st.ext_y : ph;
        ca0 = st.in_use ? st.atlas : 8'd0;

        bx_a = s2 + {2'b00, cx0} + {2'b00, pw};
        wrap = bx_a > {2'b00, cfg.max_w};

        // New row starts at extent minus spacing, floored at zero.
        cy_drop = (ey0 >= {8'd0, cfg.spacing}) ? ey0 - {8'd0, cfg.spacing} : 16'd0;
        by_drop = s2 + {2'b00, cy_drop} + {2'b00, ph};
        over    = wrap && (by_drop > {2'b00, cfg.max_h});

        // A rejected rectangle never closes the open atlas.
        has_room  = ({1'b0, ca0} + 9'd1) < 9'(MAX_ATLASES);
        new_atlas = over && has_room && !reject0;
        place     = !reject0 && !(over && !has_room);

        cx = wrap ? 16'd0 : cx0;
        cy = new_atlas ? 16'd0 : (wrap ? cy_drop : cy0);
        ex = new_atlas ? 16'd0 : ex0;
        ey = new_atlas ? ph : ey0;
        ca = new_atlas ? ca0 + 8'd1 : ca0;

        bx = s2 + {2'b00, cx} + {2'b00, pw};
        by = s2 + {2'b00, cy} + {2'b00, ph};

        st_mid = st;
        if (place)
        begin
            st_mid.ext_x  = clip16((bx > {2'b00, ex}) ? bx : {2'b00, ex});
            st_mid.ext_y  = clip16((by > {2'b00, ey}) ? by : {2'b00, ey});
            st_mid.cur_x  = clip16(bx);
            st_mid.cur_y  = cy;
            st_mid.atlas  = ca;
            st_mid.in_use = 1'b1;
        end

        ext_res = '{kind: KIND_EXTENT, pos_x: ex0, pos_y: ey0, atlas: ca0,
                    rotated: 1'b0, run_end: 1'b0};

        if (place)
        begin
            main_res = '{kind: KIND_PLACE, pos_x: clip16(sp18 + {2'b00, cx}),
                         pos_y: clip16(sp18 + {2'b00, cy}), atlas: ca,
                         rotated: rot, run_end: 1'b0};
        end
        else
        begin
            main_res = '{kind: KIND_REJECT, pos_x: 16'd0, pos_y: 16'd0,
                         atlas: st.atlas, rotated: 1'b0, run_end: 1'b0};
        end

        fin_emit = fin && st_mid.in_use;
        fin_res  = '{kind: KIND_EXTENT, pos_x: st_mid.ext_x, pos_y: st_mid.ext_y,
                     atlas: st_mid.atlas, rotated: 1'b0, run_end: 1'b1};

        st_next = fin_emit ? '0 : st_mid;

        // Compact results into emission order; mark the last one.
        res[2] = fin_res;
        if (new_atlas)
        begin
            res[0] = ext_res;
            res[1] = main_res;
            res[1].run_end = !fin_emit;
        end
        else
        begin
            res[0] = main_res;
            res[0].run_end = !fin_emit;
            res[1] = fin_res;
        end
        res_n = 2'd1 + {1'b0, new_atlas} + {1'b0, fin_emit};
    end

endmodule

// ===== rtl/srp_queue.sv =====
module srp_queue
    import srp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  result_t    push_res [MAX_RESULTS],
    input  logic [1:0] push_n,
    output logic       room,
    output logic       out_valid,
    input  logic       out_ready,
    output result_t    head
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    result_t         mem [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [PW:0]     count_reg, count_next, count_after_pop;
    logic            pop;

    always_comb
    begin
        pop             = out_valid && out_ready;
        count_after_pop = count_reg - {{PW{1'b0}}, pop};
        room            = count_after_pop <= (PW+1)'(QUEUE_DEPTH - MAX_RESULTS);
        wr_ptr_next     = wr_ptr_reg + PW'(push_n);
        rd_ptr_next     = rd_ptr_reg + {{(PW-1){1'b0}}, pop};
        count_next      = count_after_pop + (PW+1)'(push_n);
        out_valid       = count_reg != '0;
        head            = mem[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            if (i < int'(push_n))
            begin
                mem[wr_ptr_reg + PW'(i)] <= push_res[i];
            end
        end
    end

endmodule

// ===== rtl/shelf_rectangle_packer_core.sv =====
// Shelf packer: rectangles arrive in caller order, are checked against the
// atlas maxima (with spacing on both sides), optionally turned tall, and
// placed left to right in rows; a full row drops to the current extent minus
// spacing, and a full atlas is closed with an extent beat before the
// rectangle goes to the origin of the next atlas. A rectangle marked final
// is followed by the extent beat of the open atlas and the packer returns to
// its reset state. Each rectangle produces one to three result beats, the
// last flagged run_end. Up to one rectangle is accepted per cycle: it is held
// in the input register while the combinational placement logic runs, and its
// beats land together in a four-entry result queue that drains one beat per
// cycle while out_ready is high. The input register advances only while the
// queue, after this cycle's pop, has room for three more beats, so multi-beat
// rectangles can stall the input.
// Write configuration only while no rectangle is in flight.
module shelf_rectangle_packer_core
    import srp_pkg::*;
#(
    parameter int MAX_ATLASES = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] rect_width,
    input  logic [15:0] rect_height,
    input  logic        final_rect,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  kind,
    output logic [15:0] pos_x,
    output logic [15:0] pos_y,
    output logic [7:0]  atlas_index,
    output logic        was_rotated,
    output logic        run_end
);

    cfg_t        cfg_reg;
    pack_state_t st_reg, st_next;
    logic        in_vld_reg;
    logic [15:0] w_reg, h_reg;
    logic        fin_reg;
    logic        fire, room;
    result_t     res [MAX_RESULTS];
    logic [1:0]  res_n, push_n;
    result_t     head;

    // Configuration registers: plain writes, no handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{max_w: 16'd4096, max_h: 16'd4096, rotate: 1'b0, spacing: 8'd0};
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_WIDTH:    cfg_reg.max_w   <= cfg_data;
                CFG_MAX_HEIGHT:   cfg_reg.max_h   <= cfg_data;
                CFG_ALLOW_ROTATE: cfg_reg.rotate  <= cfg_data[0];
                CFG_SPACING:      cfg_reg.spacing <= cfg_data[7:0];
                default:          cfg_reg         <= cfg_reg;
            endcase
        end
    end

    // Advance the held rectangle once the queue can take all of its beats.
    assign fire     = in_vld_reg && room;
    assign in_ready = !in_vld_reg || fire;
    assign push_n   = fire ? res_n : 2'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    // Hold the rectangle payload until it is placed.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            w_reg   <= rect_width;
            h_reg   <= rect_height;
            fin_reg <= final_rect;
        end
    end

    // Packing state: cursors, extent, atlas number; update only on fire.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= '0;
        end
        else if (fire)
        begin
            st_reg <= st_next;
        end
    end

    srp_place #(
        .MAX_ATLASES (MAX_ATLASES)
    ) u_place (
        .cfg     (cfg_reg),
        .st      (st_reg),
        .rect_w  (w_reg),
        .rect_h  (h_reg),
        .fin     (fin_reg),
        .res     (res),
        .res_n   (res_n),
        .st_next (st_next)
    );

    srp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_res  (res),
        .push_n    (push_n),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign kind        = head.kind;
    assign pos_x       = head.pos_x;
    assign pos_y       = head.pos_y;
    assign atlas_index = head.atlas;
    assign was_rotated = head.rotated;
    assign run_end     = head.run_end;

    // A final rectangle leaves the packer idle for the next set.
    a_final_clears: assert property (@(posedge clk) disable iff (!rst_n)
        fire && fin_reg |=> !st_reg.in_use)
        else $error("packer state not cleared after final rectangle");

    // A rejected non-final rectangle leaves the packing state untouched.
    a_reject_stable: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !fin_reg && (res_n == 2'd1) && (res[0].kind == KIND_REJECT)
        |=> $stable(st_reg))
        else $error("rejected rectangle changed packing state");

    // The atlas number never runs past the configured count.
    a_atlas_range: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, st_reg.atlas} < 9'(MAX_ATLASES)))
        else $error("atlas number out of range");

endmodule

// ===== sim/shelf_rectangle_packer_core_tb.sv =====
`timescale 1ns / 100ps

module shelf_rectangle_packer_core_tb
    import srp_pkg::*;
();

    localparam int CLK_PERIOD     = 4;
    localparam int RESET_CYCLES   = 9;
    localparam int ATLAS_COUNT    = 256;
    // The result queue drains one beat per cycle while out_ready is high, behind
    // the input register, so TAIL_CYCLES covers anything still moving inside the block.
    localparam int TAIL_CYCLES    = 8;
    // Longest legal quiet stretch is a phase change plus a rare stall run.
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [15:0] w;
        logic [15:0] h;
        logic        fin;
    } rect_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = CFG_MAX_WIDTH;
    logic [15:0] cfg_data = 16'd0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [15:0] rect_width = 16'd0;
    logic [15:0] rect_height = 16'd0;
    logic        final_rect = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  kind;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [7:0]  atlas_index;
    logic        was_rotated;
    logic        run_end;

    // Pending rectangles for the driver and beats the packer still owes us.
    rect_t   pending_rects[$];
    result_t expected_beats[$];
    rect_t   next_rect;
    result_t oldest_beat;

    // Local copy of the configuration registers (reset values).
    logic [15:0] cfg_max_w = 16'd4096;
    logic [15:0] cfg_max_h = 16'd4096;
    logic        cfg_rotate = 1'b0;
    logic [7:0]  cfg_spacing = 8'd0;

    // Local copy of the packing state.
    logic [16:0] pk_cur_x = '0;
    logic [16:0] pk_cur_y = '0;
    logic [15:0] pk_ext_x = '0;
    logic [15:0] pk_ext_y = '0;
    logic [7:0]  pk_atlas = '0;
    logic        pk_in_use = 1'b0;

    bit idle_on = 1'b1;
    int mismatches = 0;
    int quiet_cycles = 0;

    shelf_rectangle_packer_core #(
        .MAX_ATLASES (ATLAS_COUNT)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .rect_width  (rect_width),
        .rect_height (rect_height),
        .final_rect  (final_rect),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .kind        (kind),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .atlas_index (atlas_index),
        .was_rotated (was_rotated),
        .run_end     (run_end)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    function automatic int unsigned sat16(input int unsigned v);
        return (v > 32'hFFFF) ? 32'hFFFF : v;
    endfunction

    function automatic result_t make_beat(input kind_t k, input int unsigned x,
                                          input int unsigned y, input int unsigned atl,
                                          input bit turned);
        result_t b;
        int unsigned xs;
        int unsigned ys;
        xs = sat16(x);
        ys = sat16(y);
        b.kind    = k;
        b.pos_x   = xs[15:0];
        b.pos_y   = ys[15:0];
        b.atlas   = atl[7:0];
        b.rotated = turned;
        b.run_end = 1'b0;
        return b;
    endfunction

    // Shelf placement of one rectangle: appends every beat it causes to
    // expected_beats and advances the local packing state.
    function automatic void place_rect(input logic [15:0] rw, input logic [15:0] rh,
                                       input logic fin);
        int unsigned w, h, sp, s2, cx, cy, ex, ey, ca, bx, by, t;
        bit turned;
        bit fits;
        result_t beats[$];
        w  = rw;
        h  = rh;
        sp = cfg_spacing;
        s2 = 2 * sp;
        if (w + s2 > cfg_max_w || h + s2 > cfg_max_h) begin
            beats = {beats, make_beat(KIND_REJECT, 0, 0, pk_atlas, 1'b0)};
        end
        else begin
            turned = cfg_rotate && (w > h);
            cx = pk_cur_x;
            cy = pk_cur_y;
            ex = pk_ext_x;
            ey = pk_ext_y;
            ca = pk_atlas;
            fits = 1'b1;
            if (turned) begin
                t = w;
                w = h;
                h = t;
            end
            // First accepted rectangle of a set opens atlas 0.
            if (!pk_in_use) begin
                cx = 0;
                cy = 0;
                ex = 0;
                ey = h;
                ca = 0;
            end
            bx = s2 + cx + w;
            by = s2 + cy + h;
            if (bx > cfg_max_w) begin
                // Drop to a new row; clamp at zero if extent is under spacing.
                cx = 0;
                cy = (ey >= sp) ? ey - sp : 0;
                bx = s2 + w;
                by = s2 + cy + h;
                if (by > cfg_max_h) begin
                    if (ca + 1 < ATLAS_COUNT) begin
                        beats = {beats, make_beat(KIND_EXTENT, ex, ey, ca, 1'b0)};
                        ca = ca + 1;
                        cx = 0;
                        cy = 0;
                        ex = 0;
                        ey = h;
                        bx = s2 + w;
                        by = s2 + h;
                    end
                    else begin
                        fits = 1'b0;
                    end
                end
            end
            if (fits) begin
                ex = sat16((ex > bx) ? ex : bx);
                ey = sat16((ey > by) ? ey : by);
                beats = {beats, make_beat(KIND_PLACE, sp + cx, sp + cy, ca, turned)};
                pk_cur_x  = 17'(sat16(cx + s2 + w));
                pk_cur_y  = 17'(cy);
                pk_ext_x  = 16'(ex);
                pk_ext_y  = 16'(ey);
                pk_atlas  = 8'(ca);
                pk_in_use = 1'b1;
            end
            else begin
                // Out of atlases: reject without touching state.
                beats = {beats, make_beat(KIND_REJECT, 0, 0, pk_atlas, 1'b0)};
            end
        end
        // End of set: report the open atlas and start over.
        if (fin && pk_in_use) begin
            beats = {beats, make_beat(KIND_EXTENT, pk_ext_x, pk_ext_y, pk_atlas, 1'b0)};
            pk_cur_x  = '0;
            pk_cur_y  = '0;
            pk_ext_x  = '0;
            pk_ext_y  = '0;
            pk_atlas  = '0;
            pk_in_use = 1'b0;
        end
        beats[beats.size() - 1].run_end = 1'b1;
        expected_beats = {expected_beats, beats};
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Driver: present the next pending rectangle, hold it until the beat is
    // taken, and predict its results at the accepting edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            rect_width  <= 16'd0;
            rect_height <= 16'd0;
            final_rect  <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                place_rect(rect_width, rect_height, final_rect);
            if (!in_valid || in_ready)
            begin
                if (pending_rects.size() != 0 && !(idle_on && $urandom_range(99) < 6))
                begin
                    next_rect   = pending_rects.pop_front();
                    in_valid    <= 1'b1;
                    rect_width  <= next_rect.w;
                    rect_height <= next_rect.h;
                    final_rect  <= next_rect.fin;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each result beat with the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    $display("%0t: unexpected beat, expected none actual kind %0d x %0d y %0d",
                             $time, kind, pos_x, pos_y);
                    mismatches++;
                end
                else
                begin
                    oldest_beat = expected_beats.pop_front();
                    check_field("kind", oldest_beat.kind, kind);
                    check_field("pos_x", oldest_beat.pos_x, pos_x);
                    check_field("pos_y", oldest_beat.pos_y, pos_y);
                    check_field("atlas_index", oldest_beat.atlas, atlas_index);
                    check_field("was_rotated", oldest_beat.rotated, was_rotated);
                    check_field("run_end", oldest_beat.run_end, run_end);
                end
            end
            out_ready <= !(idle_on && $urandom_range(99) < 6);
        end
    end

    // Watchdog: end the run if no beat moves on either side for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    function automatic void queue_rect(input int unsigned w, input int unsigned h,
                                       input bit fin);
        rect_t r;
        r.w   = w[15:0];
        r.h   = h[15:0];
        r.fin = fin;
        pending_rects = {pending_rects, r};
    endfunction

    // Mostly sizes that fit (many small, some exact fits), plus zeros and
    // full-range values that exercise every input bit and the reject path.
    function automatic int unsigned rand_dim(input int unsigned lim);
        int unsigned room;
        int unsigned pick;
        room = (lim > 2 * cfg_spacing) ? lim - 2 * cfg_spacing : 0;
        pick = $urandom_range(99);
        if (pick < 8)
            return $urandom_range(65535);
        if (pick < 14)
            return 0;
        if (pick < 22)
            return room;
        return $urandom_range(room / 3);
    endfunction

    // Write all four registers; upper data bits of the narrow ones carry junk.
    task automatic load_config(input int unsigned mw, input int unsigned mh,
                               input bit rot, input int unsigned sp);
        logic [14:0] junk_rot;
        logic [7:0]  junk_sp;
        junk_rot = 15'($urandom);
        junk_sp  = 8'($urandom);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MAX_WIDTH;
        cfg_data  <= mw[15:0];
        @(posedge clk);
        cfg_index <= CFG_MAX_HEIGHT;
        cfg_data  <= mh[15:0];
        @(posedge clk);
        cfg_index <= CFG_ALLOW_ROTATE;
        cfg_data  <= {junk_rot, rot};
        @(posedge clk);
        cfg_index <= CFG_SPACING;
        cfg_data  <= {junk_sp, sp[7:0]};
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_max_w   = mw[15:0];
        cfg_max_h   = mh[15:0];
        cfg_rotate  = rot;
        cfg_spacing = sp[7:0];
    endtask

    // Hold off until every rectangle is in and every owed beat is out.
    // Sample on the falling edge so the driver's updates have settled.
    task automatic drain_packer();
        while (pending_rects.size() != 0 || in_valid || expected_beats.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        int phase;
        int count;
        int set_len;
        int k;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset configuration: size extremes, rejects, row drop, new atlas,
        // final on a lone rectangle and final on a reject with no atlas open.
        queue_rect(10, 20, 0);
        queue_rect(4096, 1, 0);
        queue_rect(4097, 5, 0);
        queue_rect(5, 4097, 0);
        queue_rect(0, 0, 0);
        queue_rect(65535, 65535, 0);
        queue_rect(4096, 4096, 0);
        queue_rect(100, 100, 1);
        queue_rect(7, 7, 1);
        queue_rect(65535, 0, 1);
        queue_rect(30, 10, 0);
        queue_rect(0, 4096, 1);
        drain_packer();

        // Rotation with spacing: turn wide ones, exact padded fit, reject.
        load_config(64, 64, 1, 3);
        queue_rect(30, 10, 0);
        queue_rect(10, 30, 0);
        queue_rect(58, 58, 0);
        queue_rect(59, 1, 0);
        queue_rect(1, 59, 0);
        queue_rect(58, 0, 0);
        queue_rect(20, 20, 1);
        drain_packer();

        // Largest maxima and spacing.
        load_config(65535, 65535, 1, 255);
        queue_rect(65025, 65025, 0);
        queue_rect(65025, 1, 0);
        queue_rect(65026, 0, 0);
        queue_rect(0, 0, 0);
        queue_rect(65535, 1, 1);
        drain_packer();

        // Random phases, each with its own setting; phase 3 runs without idling.
        for (phase = 0; phase < 6; phase++)
        begin
            idle_on = (phase != 3);
            case (phase)
                0: load_config(65535, 65535, 1, 255);
                1: load_config(1, 1, $urandom_range(1), 0);
                4: load_config($urandom_range(65535, 1), $urandom_range(65535, 1),
                               $urandom_range(1), $urandom_range(255));
                5: load_config(200, 40, 1, $urandom_range(20));
                default: load_config($urandom_range(300, 16), $urandom_range(300, 16),
                                     $urandom_range(1), $urandom_range(6));
            endcase
            count = 0;
            while (count < 37)
            begin
                if ($urandom_range(99) < 80)
                begin
                    set_len = $urandom_range(10, 1);
                    for (k = 0; k < set_len; k++)
                        queue_rect(rand_dim(cfg_max_w), rand_dim(cfg_max_h), k == set_len - 1);
                    count += set_len;
                end
                else
                begin
                    queue_rect($urandom_range(65535), $urandom_range(65535),
                               $urandom_range(1));
                    count++;
                end
            end
            drain_packer();
        end

        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
